@@ hdl/rebd_pkg.sv @@
// Shared types and constants for the rotary encoder and button decoder.
package rebd_pkg;

   // Widths fixed by the interface.
   localparam int TIME_WIDTH          = 32;
   localparam int MS_WIDTH            = 16;
   localparam int FIELD_WIDTH         = 16;
   localparam int CSR_INDEX_WIDTH     = 1;
   localparam int COUNT_WIDTH_DEFAULT = 16;

   // Reset values of the configuration registers.
   localparam logic [MS_WIDTH-1:0] DEBOUNCE_MS_RESET   = 16'd10;
   localparam logic [MS_WIDTH-1:0] LONG_PRESS_MS_RESET = 16'd1000;

   // Request kinds.
   localparam logic [1:0] REQ_SAMPLE = 2'd0;
   localparam logic [1:0] REQ_TICK   = 2'd1;
   localparam logic [1:0] REQ_CLEAR  = 2'd2;

   // Configuration register indexes.
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_DEBOUNCE   = 1'b0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_LONG_PRESS = 1'b1;

   // Phase tracking states.
   typedef enum logic [2:0] {
      PH_WAIT,
      PH_PUSH_L,
      PH_START_R,
      PH_TURN_L,
      PH_TURN_R,
      PH_FIN_L,
      PH_FIN_R
   } rebd_phase_type;

   // Input item.
   typedef struct packed {
      logic [1:0] req_type;
      logic       pin_a;
      logic       pin_b;
   } rebd_req_type;

   // Result item.
   typedef struct packed {
      logic                   input_detected;
      logic [FIELD_WIDTH-1:0] left_count;
      logic [FIELD_WIDTH-1:0] right_count;
      logic [FIELD_WIDTH-1:0] push_count;
      logic [FIELD_WIDTH-1:0] long_press_count;
      logic                   button_down;
   } rebd_rsp_type;

endpackage

@@ hdl/rotary_encoder_button_decoder_core.sv @@
// Top level of the rotary encoder and push button decoder.
//
// Usage: each request transfer carries a pin sample (A and B levels), a
// millisecond tick or a clear command. Every request produces exactly one
// response transfer holding a snapshot of the detent, push and long press
// counters, the detection flag and the button level after the update.
// Response valid rises in the cycle after the request transfer. The decoder
// state and the response register are updated in the same cycle, so one request
// is taken every cycle while responses drain; the single response register sets
// this figure. While a response waits, a new request is still taken in the
// cycle the receiver takes the waiting one. When the receiver stalls with a
// response held, req_ready falls and the held response stays unchanged.
// Reset (synchronous, active high) returns the phase tracker to waiting,
// zeroes time, marks and counters, sets the last A level high, loads the
// default debounce and long press times and empties the response register.
// Configuration writes through csr_we take effect on the next request.
module rotary_encoder_button_decoder_core #(
   parameter int COUNT_WIDTH = rebd_pkg::COUNT_WIDTH_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  rebd_pkg::rebd_req_type               req_data,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output rebd_pkg::rebd_rsp_type               rsp_data,
   input  logic                                 csr_we,
   input  logic [rebd_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [rebd_pkg::MS_WIDTH-1:0]        csr_wdata
);
   import rebd_pkg::*;

   localparam logic [COUNT_WIDTH-1:0] COUNT_ONE = COUNT_WIDTH'(1);
   localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

   // Configuration registers.
   logic [MS_WIDTH-1:0] debounce_ms_ff;
   logic [MS_WIDTH-1:0] long_press_ms_ff;

   // Decoder state.
   rebd_phase_type         phase_ff, phase_in;
   logic [TIME_WIDTH-1:0]  now_ms_ff, now_ms_in;
   logic [TIME_WIDTH-1:0]  last_event_ff, last_event_in;
   logic [TIME_WIDTH-1:0]  press_mark_ff, press_mark_in;
   logic                   detected_ff, detected_in;
   logic [COUNT_WIDTH-1:0] left_ff, left_in;
   logic [COUNT_WIDTH-1:0] right_ff, right_in;
   logic [COUNT_WIDTH-1:0] short_ff, short_in;
   logic [COUNT_WIDTH-1:0] long_ff, long_in;
   logic                   last_a_ff, last_a_in;

   // Response register.
   logic         rsp_valid_ff, rsp_valid_in;
   rebd_rsp_type rsp_data_ff, rsp_data_in;

   logic                  req_fire;
   logic                  ph_hh, ph_ll, ph_hl, ph_lh;
   logic [TIME_WIDTH-1:0] held_ms;
   logic [TIME_WIDTH-1:0] tick_ms;
   logic [TIME_WIDTH-1:0] since_event_ms;

   // A request is taken whenever the response register is free or draining.
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_fire  = req_valid && req_ready;

   // Level pairs of the current sample.
   assign ph_hh = req_data.pin_a && req_data.pin_b;
   assign ph_ll = !req_data.pin_a && !req_data.pin_b;
   assign ph_hl = req_data.pin_a && !req_data.pin_b;
   assign ph_lh = !req_data.pin_a && req_data.pin_b;

   // Time differences, modulo the time width.
   assign held_ms        = now_ms_ff - press_mark_ff;
   assign tick_ms        = now_ms_ff + TIME_WIDTH'(1);
   assign since_event_ms = tick_ms - last_event_ff;

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         debounce_ms_ff   <= DEBOUNCE_MS_RESET;
         long_press_ms_ff <= LONG_PRESS_MS_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_DEBOUNCE:   debounce_ms_ff   <= csr_wdata;
            CSR_LONG_PRESS: long_press_ms_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Next state of the decoder for the request at the port.
   always_comb begin
      phase_in      = phase_ff;
      now_ms_in     = now_ms_ff;
      last_event_in = last_event_ff;
      press_mark_in = press_mark_ff;
      detected_in   = detected_ff;
      left_in       = left_ff;
      right_in      = right_ff;
      short_in      = short_ff;
      long_in       = long_ff;
      last_a_in     = last_a_ff;

      case (req_data.req_type)
         REQ_SAMPLE: begin
            last_a_in     = req_data.pin_a;
            last_event_in = now_ms_ff;
            case (phase_ff)
               PH_WAIT: begin
                  if (ph_hl) begin
                     phase_in = PH_START_R;
                  end else if (ph_lh) begin
                     phase_in      = PH_PUSH_L;
                     press_mark_in = now_ms_ff;
                  end
               end
               PH_PUSH_L: begin
                  if (ph_hh) begin
                     phase_in = PH_WAIT;
                     // A release counts only once the debounce time is exceeded.
                     if (held_ms > {{(TIME_WIDTH-MS_WIDTH){1'b0}}, debounce_ms_ff}) begin
                        detected_in = 1'b1;
                        if (held_ms < {{(TIME_WIDTH-MS_WIDTH){1'b0}}, long_press_ms_ff}
                            && short_ff != COUNT_MAX) begin
                           short_in = short_ff + COUNT_ONE;
                        end
                     end
                  end else if (ph_ll) begin
                     phase_in = PH_TURN_L;
                  end
               end
               PH_START_R: begin
                  if (ph_hh) begin
                     phase_in = PH_WAIT;
                  end else if (ph_ll) begin
                     phase_in = PH_TURN_R;
                  end
               end
               PH_TURN_L: begin
                  if (ph_lh) begin
                     phase_in = PH_PUSH_L;
                  end else if (ph_hl) begin
                     phase_in = PH_FIN_L;
                  end
               end
               PH_TURN_R: begin
                  if (ph_hl) begin
                     phase_in = PH_START_R;
                  end else if (ph_lh) begin
                     phase_in = PH_FIN_R;
                  end
               end
               PH_FIN_L: begin
                  if (ph_ll) begin
                     phase_in = PH_TURN_L;
                  end else if (ph_hh) begin
                     // Full left detent; the right count restarts.
                     phase_in      = PH_WAIT;
                     right_in      = '0;
                     left_in       = (left_ff == COUNT_MAX) ? left_ff : left_ff + COUNT_ONE;
                     detected_in   = 1'b1;
                     press_mark_in = now_ms_ff;
                  end
               end
               PH_FIN_R: begin
                  if (ph_ll) begin
                     phase_in = PH_TURN_R;
                  end else if (ph_hh) begin
                     // Full right detent; the left count restarts.
                     phase_in      = PH_WAIT;
                     left_in       = '0;
                     right_in      = (right_ff == COUNT_MAX) ? right_ff : right_ff + COUNT_ONE;
                     detected_in   = 1'b1;
                     press_mark_in = now_ms_ff;
                  end
               end
               default: begin
                  phase_in = PH_WAIT;
               end
            endcase
         end
         REQ_TICK: begin
            now_ms_in = tick_ms;
            // Each long press interval of holding adds one long press.
            if (phase_ff == PH_PUSH_L
                && since_event_ms >= {{(TIME_WIDTH-MS_WIDTH){1'b0}}, long_press_ms_ff}) begin
               last_event_in = tick_ms;
               long_in       = (long_ff == COUNT_MAX) ? long_ff : long_ff + COUNT_ONE;
               detected_in   = 1'b1;
            end
         end
         REQ_CLEAR: begin
            detected_in = 1'b0;
            left_in     = '0;
            right_in    = '0;
            short_in    = '0;
            // A button still held keeps its long press count.
            if (phase_ff != PH_PUSH_L) begin
               long_in = '0;
            end
         end
         default: ;
      endcase
   end

   // Response snapshot and its valid flag.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (req_fire) begin
         rsp_valid_in                 = 1'b1;
         rsp_data_in.input_detected   = detected_in;
         rsp_data_in.left_count       = FIELD_WIDTH'(left_in);
         rsp_data_in.right_count      = FIELD_WIDTH'(right_in);
         rsp_data_in.push_count       = FIELD_WIDTH'(short_in);
         rsp_data_in.long_press_count = FIELD_WIDTH'(long_in);
         rsp_data_in.button_down      = !last_a_in;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Decoder state register, updated on each request transfer.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_WAIT;
         now_ms_ff     <= '0;
         last_event_ff <= '0;
         press_mark_ff <= '0;
         detected_ff   <= 1'b0;
         left_ff       <= '0;
         right_ff      <= '0;
         short_ff      <= '0;
         long_ff       <= '0;
         last_a_ff     <= 1'b1;
      end else if (req_fire) begin
         phase_ff      <= phase_in;
         now_ms_ff     <= now_ms_in;
         last_event_ff <= last_event_in;
         press_mark_ff <= press_mark_in;
         detected_ff   <= detected_in;
         left_ff       <= left_in;
         right_ff      <= right_in;
         short_ff      <= short_in;
         long_ff       <= long_in;
         last_a_ff     <= last_a_in;
      end
   end

   // Response register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

@@ hdl/rebd_checker.sv @@
// Port-level assertions for the decoder core and the bind that attaches them.
module rebd_checker (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_valid,
   input logic                   req_ready,
   input logic                   rsp_valid,
   input logic                   rsp_ready,
   input rebd_pkg::rebd_rsp_type rsp_data
);

   // The response register is empty right after reset.
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   // Every request transfer yields a response in the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> rsp_valid)
      else $error("request transfer without response");

   // With no response pending, the block always takes a request.
   assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("request stalled with empty response register");

   // A stalled response holds its contents.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_data)))
      else $error("stalled response changed");

   // A detent in one direction zeroes the other, so both are never nonzero.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.left_count == '0 || rsp_data.right_count == '0))
      else $error("left and right counts both nonzero");

endmodule

bind rotary_encoder_button_decoder_core rebd_checker u_rebd_checker (.*);

@@ sim/rotary_encoder_button_decoder_core_tb.sv @@
// Self-checking testbench for the rotary encoder and push button decoder core.
`timescale 1ns / 1ps

module rotary_encoder_button_decoder_core_tb;
   import rebd_pkg::*;

   localparam int COUNT_WIDTH = COUNT_WIDTH_DEFAULT;
   localparam logic [31:0] COUNT_MAX = 32'((64'd1 << COUNT_WIDTH) - 64'd1);
   localparam int CYCLE_LIMIT = 3_000_000;
   localparam int ERROR_REPORT_LIMIT = 10;
   localparam int RANDOM_ITEMS_PER_PHASE = 300;

   // Request code that the decoder ignores.
   localparam logic [1:0] REQ_RESERVED = 2'd3;

   // Pin level pairs {A, B} for one full detent, first step in the top bits.
   localparam logic [7:0] LEFT_DETENT  = 8'b01_00_10_11;
   localparam logic [7:0] RIGHT_DETENT = 8'b10_00_01_11;

   logic clock;
   logic reset;
   logic req_valid;
   logic req_ready;
   rebd_req_type req_data;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   rebd_rsp_type rsp_data;
   logic csr_we;
   logic [CSR_INDEX_WIDTH-1:0] csr_index;
   logic [MS_WIDTH-1:0] csr_wdata;

   rotary_encoder_button_decoder_core #(
      .COUNT_WIDTH(COUNT_WIDTH)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data(rsp_data),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   // Decoder state as the testbench expects it.
   rebd_phase_type phase_q = PH_WAIT;
   logic [31:0] now_ms_q = '0;
   logic [31:0] last_event_ms_q = '0;
   logic [31:0] press_mark_ms_q = '0;
   logic detected_q = 1'b0;
   logic [31:0] left_detents_q = '0;
   logic [31:0] right_detents_q = '0;
   logic [31:0] short_presses_q = '0;
   logic [31:0] long_presses_q = '0;
   logic last_a_q = 1'b1;
   logic [MS_WIDTH-1:0] debounce_cfg = DEBOUNCE_MS_RESET;
   logic [MS_WIDTH-1:0] long_press_cfg = LONG_PRESS_MS_RESET;

   rebd_rsp_type expected_snapshots[$];
   rebd_rsp_type checked_snapshot;
   int error_count = 0;
   int decoder_items = 0;
   int cycle_count = 0;
   int stall_left = 0;
   bit quiet_mode = 1'b0;

   // Clock generation.
   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Watchdog on the total run length.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("rotary_encoder_button_decoder_core_tb NOT OK");
         $finish;
      end
   end

   function automatic logic [31:0] saturating_bump(input logic [31:0] value);
      if (value >= COUNT_MAX) return COUNT_MAX;
      return value + 32'd1;
   endfunction

   // Apply one request to the expected state and return the snapshot it yields.
   function automatic rebd_rsp_type advance_decoder(input rebd_req_type item);
      logic hh, ll, hl, lh;
      logic [31:0] held;
      rebd_rsp_type snap;
      hh = item.pin_a & item.pin_b;
      ll = ~item.pin_a & ~item.pin_b;
      hl = item.pin_a & ~item.pin_b;
      lh = ~item.pin_a & item.pin_b;
      case (item.req_type)
         REQ_SAMPLE: begin
            last_a_q = item.pin_a;
            last_event_ms_q = now_ms_q;
            case (phase_q)
               PH_WAIT: begin
                  if (hl) phase_q = PH_START_R;
                  else if (lh) begin
                     phase_q = PH_PUSH_L;
                     press_mark_ms_q = last_event_ms_q;
                  end
               end
               PH_PUSH_L: begin
                  if (hh) begin
                     held = last_event_ms_q - press_mark_ms_q;
                     phase_q = PH_WAIT;
                     if (held > {16'd0, debounce_cfg}) begin
                        if (held < {16'd0, long_press_cfg})
                           short_presses_q = saturating_bump(short_presses_q);
                        detected_q = 1'b1;
                     end
                  end else if (ll) phase_q = PH_TURN_L;
               end
               PH_START_R: begin
                  if (hh) phase_q = PH_WAIT;
                  else if (ll) phase_q = PH_TURN_R;
               end
               PH_TURN_L: begin
                  if (lh) phase_q = PH_PUSH_L;
                  else if (hl) phase_q = PH_FIN_L;
               end
               PH_TURN_R: begin
                  if (hl) phase_q = PH_START_R;
                  else if (lh) phase_q = PH_FIN_R;
               end
               PH_FIN_L: begin
                  if (ll) phase_q = PH_TURN_L;
                  else if (hh) begin
                     phase_q = PH_WAIT;
                     right_detents_q = '0;
                     left_detents_q = saturating_bump(left_detents_q);
                     detected_q = 1'b1;
                     press_mark_ms_q = last_event_ms_q;
                  end
               end
               PH_FIN_R: begin
                  if (ll) phase_q = PH_TURN_R;
                  else if (hh) begin
                     phase_q = PH_WAIT;
                     left_detents_q = '0;
                     right_detents_q = saturating_bump(right_detents_q);
                     detected_q = 1'b1;
                     press_mark_ms_q = last_event_ms_q;
                  end
               end
               default: phase_q = PH_WAIT;
            endcase
         end
         REQ_TICK: begin
            now_ms_q = now_ms_q + 32'd1;
            if (phase_q == PH_PUSH_L &&
                (now_ms_q - last_event_ms_q) >= {16'd0, long_press_cfg}) begin
               last_event_ms_q = now_ms_q;
               long_presses_q = saturating_bump(long_presses_q);
               detected_q = 1'b1;
            end
         end
         REQ_CLEAR: begin
            detected_q = 1'b0;
            left_detents_q = '0;
            right_detents_q = '0;
            short_presses_q = '0;
            // A held button keeps its long press count.
            if (phase_q != PH_PUSH_L) long_presses_q = '0;
         end
         default: ;
      endcase
      snap.input_detected = detected_q;
      snap.left_count = left_detents_q[FIELD_WIDTH-1:0];
      snap.right_count = right_detents_q[FIELD_WIDTH-1:0];
      snap.push_count = short_presses_q[FIELD_WIDTH-1:0];
      snap.long_press_count = long_presses_q[FIELD_WIDTH-1:0];
      snap.button_down = ~last_a_q;
      return snap;
   endfunction

   function automatic string describe_snapshot(input rebd_rsp_type snap);
      return $sformatf("det=%0d left=%0d right=%0d push=%0d long=%0d down=%0d",
                       snap.input_detected, snap.left_count, snap.right_count,
                       snap.push_count, snap.long_press_count, snap.button_down);
   endfunction

   task automatic note_error(input string message);
      error_count++;
      if (error_count <= ERROR_REPORT_LIMIT) $display("ERROR: %s", message);
   endtask

   // Idle length: mostly none or short, now and then long.
   function automatic int idle_gap();
      int roll;
      if (quiet_mode) return 0;
      roll = $urandom_range(0, 99);
      if (roll < 55) return 0;
      if (roll < 90) return $urandom_range(1, 3);
      return $urandom_range(4, 30);
   endfunction

   // Receiver side: random stalls on the response channel.
   always @(negedge clock) begin
      if (stall_left != 0) begin
         rsp_ready <= 1'b0;
         stall_left <= stall_left - 1;
      end else begin
         rsp_ready <= 1'b1;
         stall_left <= idle_gap();
      end
   end

   // Compare every response transfer with the oldest expected snapshot.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_snapshots.size() == 0) begin
            note_error($sformatf("response with no request outstanding: %s",
                                 describe_snapshot(rsp_data)));
         end else begin
            checked_snapshot = expected_snapshots.pop_front();
            if (rsp_data.input_detected !== checked_snapshot.input_detected ||
                rsp_data.left_count !== checked_snapshot.left_count ||
                rsp_data.right_count !== checked_snapshot.right_count ||
                rsp_data.push_count !== checked_snapshot.push_count ||
                rsp_data.long_press_count !== checked_snapshot.long_press_count ||
                rsp_data.button_down !== checked_snapshot.button_down) begin
               note_error($sformatf("snapshot mismatch: expected %s, got %s",
                                    describe_snapshot(checked_snapshot),
                                    describe_snapshot(rsp_data)));
            end
         end
      end
   end

   // Send one request; returns just after the transfer edge with valid still high.
   task automatic send_request(input rebd_req_type item);
      int gap;
      gap = idle_gap();
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data <= item;
      do @(posedge clock); while (!req_ready);
      expected_snapshots.push_back(advance_decoder(item));
      if (item.req_type != REQ_RESERVED) decoder_items++;
   endtask

   task automatic send_sample(input logic pin_a, input logic pin_b);
      rebd_req_type item;
      item.req_type = REQ_SAMPLE;
      item.pin_a = pin_a;
      item.pin_b = pin_b;
      send_request(item);
   endtask

   // Send a run of samples packed as {A, B} pairs, first pair in the top bits.
   task automatic send_samples(input logic [31:0] levels, input int count);
      for (int i = count - 1; i >= 0; i--) send_sample(levels[2*i+1], levels[2*i]);
   endtask

   task automatic send_ticks(input int count);
      rebd_req_type item;
      item.req_type = REQ_TICK;
      item.pin_a = 1'($urandom_range(0, 1));
      item.pin_b = 1'($urandom_range(0, 1));
      repeat (count) send_request(item);
   endtask

   task automatic send_clear();
      rebd_req_type item;
      item.req_type = REQ_CLEAR;
      item.pin_a = 1'($urandom_range(0, 1));
      item.pin_b = 1'($urandom_range(0, 1));
      send_request(item);
   endtask

   task automatic send_reserved(input logic pin_a, input logic pin_b);
      rebd_req_type item;
      item.req_type = REQ_RESERVED;
      item.pin_a = pin_a;
      item.pin_b = pin_b;
      send_request(item);
   endtask

   // Drop valid and wait until every expected snapshot has arrived.
   task automatic drain_responses();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_snapshots.size() != 0) @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_INDEX_WIDTH-1:0] index,
                            input logic [MS_WIDTH-1:0] value);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      if (index == CSR_DEBOUNCE) debounce_cfg = value;
      else long_press_cfg = value;
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   // Timing registers are only changed with the decoder idle.
   task automatic apply_timing(input logic [MS_WIDTH-1:0] debounce,
                               input logic [MS_WIDTH-1:0] long_press);
      drain_responses();
      write_csr(CSR_DEBOUNCE, debounce);
      write_csr(CSR_LONG_PRESS, long_press);
   endtask

   // Ignored request codes, ticks and clears straight out of reset.
   task automatic test_idle_requests();
      send_reserved(1'b0, 1'b0);
      send_reserved(1'b1, 1'b1);
      send_ticks(1);
      send_clear();
   endtask

   // Full detents both ways and backtracking inside a detent.
   task automatic test_detents();
      send_samples(32'(LEFT_DETENT), 4);
      send_samples(32'(RIGHT_DETENT), 4);
      send_samples(32'(RIGHT_DETENT), 4);
      // Start to the right, then back to rest.
      send_samples(32'(8'b10_11), 2);
      // Left turn that reverses twice and ends as a very short press.
      send_samples(32'(12'b01_00_10_00_01_11), 6);
      // Right turn that reverses twice before it completes.
      send_samples(32'(16'b10_00_10_00_01_00_01_11), 8);
      send_samples(32'(LEFT_DETENT), 4);
   endtask

   // Short press, press inside debounce, long presses and clear while held.
   task automatic test_button_timing();
      apply_timing(16'd2, 16'd4);
      send_sample(1'b0, 1'b1);
      send_ticks(3);
      send_sample(1'b1, 1'b1);
      send_sample(1'b0, 1'b1);
      send_ticks(2);
      send_sample(1'b1, 1'b1);
      send_sample(1'b0, 1'b1);
      send_ticks(5);
      send_sample(1'b1, 1'b1);
      send_sample(1'b0, 1'b1);
      send_ticks(9);
      send_clear();
      send_sample(1'b1, 1'b1);
      send_clear();
   endtask

   // Register extremes: no debounce with the shortest hold, and the longest times.
   task automatic test_timing_extremes();
      apply_timing(16'd0, 16'd1);
      send_samples(32'(4'b01_11), 2);
      send_sample(1'b0, 1'b1);
      send_ticks(2);
      send_sample(1'b1, 1'b1);
      apply_timing(16'hFFFF, 16'hFFFF);
      send_sample(1'b0, 1'b1);
      send_ticks(3);
      send_sample(1'b1, 1'b1);
      send_clear();
   endtask

   // Back-to-back detents and a zero long press time while held.
   task automatic test_zero_long_press();
      quiet_mode = 1'b1;
      for (int i = 0; i < 6; i++) send_samples(32'(LEFT_DETENT), 4);
      for (int i = 0; i < 6; i++) send_samples(32'(RIGHT_DETENT), 4);
      send_clear();
      // A zero long press time counts one long press per tick while held.
      apply_timing(16'd0, 16'd0);
      send_sample(1'b0, 1'b1);
      send_ticks(6);
      send_clear();
      send_sample(1'b1, 1'b1);
      send_clear();
      quiet_mode = 1'b0;
   endtask

   // One random piece of traffic, mostly well-formed detents and presses.
   task automatic random_burst();
      int kind;
      int steps;
      int hold;
      int hold_cap;
      logic [7:0] detent;
      kind = $urandom_range(0, 99);
      if (kind < 30) begin
         detent = $urandom_range(0, 1) ? LEFT_DETENT : RIGHT_DETENT;
         steps = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 3) : 4;
         for (int i = 0; i < steps; i++) begin
            send_sample(detent[7-2*i], detent[6-2*i]);
            if ($urandom_range(0, 3) == 0) send_ticks($urandom_range(1, 3));
            if ($urandom_range(0, 9) == 0)
               send_sample(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
         end
      end else if (kind < 60) begin
         hold_cap = 2 * int'(long_press_cfg) + int'(debounce_cfg) + 3;
         if (hold_cap > 40) hold_cap = 40;
         hold = $urandom_range(0, hold_cap);
         send_sample(1'b0, 1'b1);
         for (int i = 0; i < hold; i++) begin
            send_ticks(1);
            if ($urandom_range(0, 19) == 0) send_sample(1'b0, 1'b1);
            if ($urandom_range(0, 39) == 0) send_clear();
         end
         if ($urandom_range(0, 4) == 0) send_sample(1'b0, 1'b0);
         else send_sample(1'b1, 1'b1);
      end else if (kind < 75) begin
         send_ticks($urandom_range(1, 5));
      end else if (kind < 80) begin
         send_clear();
      end else if (kind < 85) begin
         send_reserved(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      end else begin
         send_sample(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      end
   endtask

   // Random traffic under several timing settings, with a full pause midway.
   task automatic test_random_traffic();
      int phase_start;
      bit paused;
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: apply_timing(DEBOUNCE_MS_RESET, LONG_PRESS_MS_RESET);
            1: apply_timing(16'd0, 16'd1);
            default: apply_timing(16'($urandom_range(0, 6)), 16'($urandom_range(1, 25)));
         endcase
         phase_start = decoder_items;
         paused = 1'b0;
         while (decoder_items - phase_start < RANDOM_ITEMS_PER_PHASE) begin
            if ($urandom_range(0, 15) == 0) quiet_mode = ~quiet_mode;
            if (!paused && decoder_items - phase_start >= RANDOM_ITEMS_PER_PHASE / 2) begin
               drain_responses();
               paused = 1'b1;
            end
            random_burst();
         end
         quiet_mode = 1'b0;
      end
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      csr_we = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_idle_requests();
      test_detents();
      test_button_timing();
      test_timing_extremes();
      test_zero_long_press();
      test_random_traffic();

      drain_responses();
      repeat (4) @(posedge clock);
      if (expected_snapshots.size() != 0)
         note_error($sformatf("%0d expected snapshots never arrived", expected_snapshots.size()));
      if (error_count == 0) begin
         $display("rotary_encoder_button_decoder_core_tb OK");
      end else begin
         $display("rotary_encoder_button_decoder_core_tb NOT OK");
      end
      $finish;
   end

endmodule

@@ rotary_encoder_button_decoder_core.f @@
hdl/rebd_pkg.sv
hdl/rotary_encoder_button_decoder_core.sv
hdl/rebd_checker.sv
sim/rotary_encoder_button_decoder_core_tb.sv
